// File: sv/sfr_pkg.sv
// Shared constants and the command type passed from the frame parser to the result sequencer.
package sfr_pkg;

    localparam int SFR_MAX_CHANNELS = 16;
    localparam int SFR_QUEUE_DEPTH  = 4;

    localparam logic [7:0] SFR_GAP_RESET   = 8'd4;
    localparam logic [7:0] SFR_VENDOR_BYTE = 8'hA8;
    localparam logic [7:0] SFR_STATUS_OK   = 8'h01;
    localparam logic [7:0] SFR_STATUS_FS   = 8'h81;
    localparam logic [6:0] SFR_HEAD_LEN    = 7'd3;
    localparam logic [7:0] SFR_MIN_CHANNELS = 8'd2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_GOOD  = 2'd1,
        CMD_ERROR = 2'd2
    } sfr_op_t;

    typedef struct packed {
        sfr_op_t     op;
        logic [4:0]  idx;
        logic [15:0] word;
        logic [5:0]  total;
        logic        fs;
        logic [15:0] good;
        logic [15:0] err;
    } sfr_cmd_t;

endpackage

// File: sv/sfr_front.sv
// Frame parser: gap timing, header checks, CRC and channel word assembly.
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_CHANNELS = SFR_MAX_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    output logic        push,
    output sfr_cmd_t    cmd
);

    logic [6:0]  pos_reg, pos_next;
    logic [7:0]  idle_reg, idle_next;
    logic [15:0] crc_reg, crc_next;
    logic [5:0]  fc_reg, fc_next;
    logic [7:0]  hold_reg, hold_next;
    logic        fs_reg, fs_next;
    logic [15:0] good_reg, good_next;
    logic [15:0] err_reg, err_next;
    logic [7:0]  gap_reg;

    logic        gap;
    logic [6:0]  pos;
    logic [15:0] crc_new;
    logic [6:0]  d;
    logic [6:0]  two_fc;
    sfr_op_t     op;
    logic [4:0]  idx;
    logic [15:0] word;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ 16'h1021;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    assign gap     = idle_reg >= gap_reg;
    assign pos     = gap ? 7'd0 : pos_reg;
    assign crc_new = crc_byte((pos == 7'd0) ? 16'h0000 : crc_reg, rx_byte);
    assign d       = pos - SFR_HEAD_LEN;
    assign two_fc  = {fc_reg, 1'b0};

    always_comb
    begin
        pos_next  = pos_reg;
        idle_next = idle_reg;
        crc_next  = crc_reg;
        fc_next   = fc_reg;
        hold_next = hold_reg;
        fs_next   = fs_reg;
        good_next = good_reg;
        err_next  = err_reg;
        push      = 1'b0;
        op        = CMD_WRITE;
        idx       = d[5:1];
        word      = {hold_reg, rx_byte};
        if (accept) begin
            if (action) begin
                if (idle_reg != 8'hFF) begin
                    idle_next = idle_reg + 8'd1;
                end
            end else begin
                idle_next = 8'd0;
                pos_next  = pos;
                if (pos == 7'd0) begin
                    if (rx_byte == SFR_VENDOR_BYTE) begin
                        crc_next = crc_new;
                        pos_next = 7'd1;
                    end
                end else begin
                    crc_next = crc_new;
                    if (pos == 7'd1) begin
                        if (rx_byte == SFR_STATUS_OK || rx_byte == SFR_STATUS_FS) begin
                            fs_next  = (rx_byte == SFR_STATUS_FS);
                            pos_next = 7'd2;
                        end else begin
                            err_next = err_reg + 16'd1;
                            pos_next = 7'd0;
                            crc_next = 16'h0000;
                            push     = 1'b1;
                            op       = CMD_ERROR;
                        end
                    end else if (pos == 7'd2) begin
                        if (rx_byte >= SFR_MIN_CHANNELS && rx_byte <= 8'(MAX_CHANNELS)) begin
                            fc_next  = rx_byte[5:0];
                            pos_next = 7'd3;
                        end else begin
                            err_next = err_reg + 16'd1;
                            pos_next = 7'd0;
                            crc_next = 16'h0000;
                            push     = 1'b1;
                            op       = CMD_ERROR;
                        end
                    end else begin
                        if (d < two_fc) begin
                            if (d[0]) begin
                                push = 1'b1;
                                op   = CMD_WRITE;
                            end else begin
                                hold_next = rx_byte;
                            end
                        end
                        if (pos < two_fc + 7'd4) begin
                            pos_next = pos + 7'd1;
                        end else if (crc_new != 16'h0000) begin
                            err_next = err_reg + 16'd1;
                            pos_next = 7'd0;
                            crc_next = 16'h0000;
                            push     = 1'b1;
                            op       = CMD_ERROR;
                        end else begin
                            good_next = good_reg + 16'd1;
                            pos_next  = 7'd0;
                            crc_next  = 16'h0000;
                            push      = 1'b1;
                            op        = CMD_GOOD;
                        end
                    end
                end
            end
        end
    end

    assign cmd.op    = op;
    assign cmd.idx   = idx;
    assign cmd.word  = word;
    assign cmd.total = fc_next;
    assign cmd.fs    = fs_next;
    assign cmd.good  = good_next;
    assign cmd.err   = err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= 7'd0;
            idle_reg <= 8'd0;
            crc_reg  <= 16'h0000;
            fc_reg   <= 6'(MAX_CHANNELS);
            hold_reg <= 8'd0;
            fs_reg   <= 1'b1;
            good_reg <= 16'd0;
            err_reg  <= 16'd0;
            gap_reg  <= SFR_GAP_RESET;
        end else begin
            pos_reg  <= pos_next;
            idle_reg <= idle_next;
            crc_reg  <= crc_next;
            fc_reg   <= fc_next;
            hold_reg <= hold_next;
            fs_reg   <= fs_next;
            good_reg <= good_next;
            err_reg  <= err_next;
            if (cfg_write) begin
                gap_reg <= cfg_data;
            end
        end
    end

endmodule

// File: sv/sfr_queue.sv
// Short command queue between the frame parser and the result sequencer.
module sfr_queue
    import sfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sfr_cmd_t push_data,
    output logic     full,
    input  logic     pop,
    output sfr_cmd_t pop_data,
    output logic     empty
);

    localparam int PW = $clog2(SFR_QUEUE_DEPTH);

    sfr_cmd_t        entry_reg [SFR_QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full     = count_reg == (PW + 1)'(SFR_QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW + 1)'(1);
            end
        end
    end

endmodule

// File: sv/sfr_back.sv
// Result sequencer: holds the channel store and emits channel and error results.
module sfr_back
    import sfr_pkg::*;
#(
    parameter int MAX_CHANNELS = SFR_MAX_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  sfr_cmd_t    cmd,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [4:0]  channel_index,
    output logic [12:0] channel_value,
    output logic [5:0]  channel_total,
    output logic        failsafe,
    output logic [15:0] good_count,
    output logic [15:0] error_count,
    output logic        last
);

    localparam int AW = $clog2(MAX_CHANNELS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t      state_reg;
    sfr_cmd_t    cur_reg;
    logic [4:0]  chan_reg;
    logic [15:0] mem [MAX_CHANNELS];
    logic [15:0] rd_data_reg;

    logic out_free;
    logic mem_we;
    logic chan_last;
    logic emit_err;
    logic emit_chan;

    assign out_free  = !out_valid || !out_stall;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty
                       && (cmd.op != CMD_ERROR || out_free);
    assign mem_we    = q_pop && (cmd.op == CMD_WRITE);
    assign chan_last = ({1'b0, chan_reg} + 6'd1) == cur_reg.total;
    assign emit_err  = q_pop && (cmd.op == CMD_ERROR);
    assign emit_chan = (state_reg == ST_EMIT) && out_free;

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[cmd.idx[AW-1:0]] <= cmd.word;
        end
        rd_data_reg <= mem[chan_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            chan_reg      <= 5'd0;
            out_valid     <= 1'b0;
            kind          <= 1'b0;
            channel_index <= 5'd0;
            channel_value <= 13'd0;
            channel_total <= 6'd0;
            failsafe      <= 1'b0;
            good_count    <= 16'd0;
            error_count   <= 16'd0;
            last          <= 1'b0;
        end else begin
            if (emit_err || emit_chan) begin
                out_valid <= 1'b1;
            end else if (!out_stall) begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop) begin
                        if (cmd.op == CMD_ERROR) begin
                            kind          <= 1'b1;
                            channel_index <= 5'd0;
                            channel_value <= 13'd0;
                            channel_total <= cmd.total;
                            failsafe      <= cmd.fs;
                            good_count    <= cmd.good;
                            error_count   <= cmd.err;
                            last          <= 1'b1;
                        end else if (cmd.op == CMD_GOOD) begin
                            cur_reg   <= cmd;
                            chan_reg  <= 5'd0;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free) begin
                        kind          <= 1'b0;
                        channel_index <= chan_reg;
                        channel_value <= rd_data_reg[15:3];
                        channel_total <= cur_reg.total;
                        failsafe      <= cur_reg.fs;
                        good_count    <= cur_reg.good;
                        error_count   <= cur_reg.err;
                        last          <= chan_last;
                        if (chan_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            chan_reg  <= chan_reg + 5'd1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/sumd_frame_receiver_unit.sv
// Top level of the SUMD frame receiver: parser, command queue and result sequencer.
//
// Each input request carries either a received UART byte (action 0) or a
// one millisecond tick (action 1). The parser takes one request per cycle
// while the command queue has room; in_stall rises only when the queue is
// full. Ticks and accepted header bytes give no result; channel words are
// written to the channel store as the sequencer pops them. A good frame
// then produces one result per channel, each through a read state and an
// emit state, as the channel store has a single read port. A rejected
// frame produces one error result. The first result of a frame follows the
// byte that ends it through the queue, the sequencer and the output
// register. Results leave from the output register; while out_stall is
// high the register holds and the queue and then the input fill up behind it.
// The gap timeout register is written through cfg_valid/cfg_data, always
// ready, and should be written only while the block is idle.
// Reset clears the frame state, the counters and the queue, sets the
// failsafe flag and a timeout of four milliseconds; the channel store is
// not cleared and needs no clearing pass.
module sumd_frame_receiver_unit
    import sfr_pkg::*;
#(
    parameter int MAX_CHANNELS = SFR_MAX_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [4:0]  channel_index,
    output logic [12:0] channel_value,
    output logic [5:0]  channel_total,
    output logic        failsafe,
    output logic [15:0] good_count,
    output logic [15:0] error_count,
    output logic        last
);

    logic     accept;
    logic     push;
    logic     full;
    logic     pop;
    logic     empty;
    sfr_cmd_t push_cmd;
    sfr_cmd_t pop_cmd;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !in_stall;

    sfr_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .action   (action),
        .rx_byte  (rx_byte),
        .cfg_write(cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .push     (push),
        .cmd      (push_cmd)
    );

    sfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_data (pop_cmd),
        .empty    (empty)
    );

    sfr_back #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pop_cmd),
        .q_empty      (empty),
        .q_pop        (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .channel_index(channel_index),
        .channel_value(channel_value),
        .channel_total(channel_total),
        .failsafe     (failsafe),
        .good_count   (good_count),
        .error_count  (error_count),
        .last         (last)
    );

endmodule

// File: test/sumd_frame_receiver_unit_test.sv
// Self-checking testbench for the SUMD frame receiver: directed and random byte and tick requests.
`timescale 1ns / 100ps

module sumd_frame_receiver_unit_test;
    import sfr_pkg::*;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_REJECT = 1'b1;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam int CRC_BYTES = 2;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS = 40;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic        kind;
        logic [4:0]  idx;
        logic [12:0] value;
        logic [5:0]  total;
        logic        fs;
        logic [15:0] good;
        logic [15:0] err;
        logic        last;
    } channel_result_t;

    class frame_scoreboard;
        channel_result_t expected_q[$];
        logic [7:0]  gap_limit;
        logic [6:0]  position;
        logic [7:0]  idle_ms;
        logic [15:0] crc;
        logic [5:0]  channels;
        logic [7:0]  high_hold;
        logic [15:0] words[SFR_MAX_CHANNELS];
        logic        fs_flag;
        logic [15:0] good_frames;
        logic [15:0] bad_frames;
        int          errors;
        int          results_seen;

        function new();
            gap_limit = SFR_GAP_RESET;
            position = '0;
            idle_ms = '0;
            crc = '0;
            channels = 6'(SFR_MAX_CHANNELS);
            high_hold = '0;
            fs_flag = 1'b1;
            good_frames = '0;
            bad_frames = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
                r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(logic kind, logic [4:0] idx, logic [12:0] value,
                                  logic is_last);
            channel_result_t res;
            res.kind = kind;
            res.idx = idx;
            res.value = value;
            res.total = channels;
            res.fs = fs_flag;
            res.good = good_frames;
            res.err = bad_frames;
            res.last = is_last;
            expected_q.push_back(res);
        endfunction

        function void reject_frame();
            bad_frames = bad_frames + 16'd1;
            position = '0;
            crc = '0;
            push_result(KIND_REJECT, 5'd0, 13'd0, 1'b1);
        endfunction

        function void note_request(logic act, logic [7:0] b);
            int total;
            int d;
            if (act == ACT_TICK) begin
                if (idle_ms != 8'hFF)
                    idle_ms = idle_ms + 8'd1;
                return;
            end
            if (idle_ms >= gap_limit) begin
                position = '0;
                crc = '0;
            end
            idle_ms = '0;
            if (position == 0) begin
                if (b == SFR_VENDOR_BYTE) begin
                    crc = crc_step(16'h0000, b);
                    position = 7'd1;
                end
                return;
            end
            crc = crc_step(crc, b);
            if (position == 1) begin
                if (b != SFR_STATUS_OK && b != SFR_STATUS_FS) begin
                    reject_frame();
                end
                else begin
                    fs_flag = (b == SFR_STATUS_FS);
                    position = 7'd2;
                end
                return;
            end
            if (position == 2) begin
                if (b < SFR_MIN_CHANNELS || b > SFR_MAX_CHANNELS) begin
                    reject_frame();
                end
                else begin
                    channels = b[5:0];
                    position = 7'd3;
                end
                return;
            end
            total = SFR_HEAD_LEN + 2 * channels + CRC_BYTES;
            d = position - SFR_HEAD_LEN;
            if (d < 2 * channels) begin
                if (d % 2 == 1)
                    words[d / 2] = {high_hold, b};
                else
                    high_hold = b;
            end
            if (position + 1 < total) begin
                position = position + 7'd1;
                return;
            end
            if (crc != 16'h0000) begin
                reject_frame();
                return;
            end
            good_frames = good_frames + 16'd1;
            position = '0;
            crc = '0;
            for (int k = 0; k < channels; k++)
                push_result(KIND_CHANNEL, k[4:0], words[k][15:3], k == channels - 1);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("MISMATCH at result %0d: %s", results_seen, msg);
        endtask

        task check_result(channel_result_t got);
            channel_result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind=%0d idx=%0d", got.kind, got.idx));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.idx != want.idx)
                report($sformatf("channel_index got %0d want %0d", got.idx, want.idx));
            if (got.value != want.value)
                report($sformatf("channel_value got %0d want %0d", got.value, want.value));
            if (got.total != want.total)
                report($sformatf("channel_total got %0d want %0d", got.total, want.total));
            if (got.fs != want.fs)
                report($sformatf("failsafe got %0d want %0d", got.fs, want.fs));
            if (got.good != want.good)
                report($sformatf("good_count got %0d want %0d", got.good, want.good));
            if (got.err != want.err)
                report($sformatf("error_count got %0d want %0d", got.err, want.err));
            if (got.last != want.last)
                report($sformatf("last got %0d want %0d", got.last, want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  rx_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [4:0]  channel_index;
    logic [12:0] channel_value;
    logic [5:0]  channel_total;
    logic        failsafe;
    logic [15:0] good_count;
    logic [15:0] error_count;
    logic        last;

    frame_scoreboard sb;
    logic [7:0]      frame_bytes[$];
    logic [15:0]     frame_words[$];
    int              frame_items = 0;
    int              send_calm = 0;
    int              idle_cycles = 0;
    bit              hold_off_req = 1'b0;

    sumd_frame_receiver_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .rx_byte(rx_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .channel_index(channel_index),
        .channel_value(channel_value),
        .channel_total(channel_total),
        .failsafe(failsafe),
        .good_count(good_count),
        .error_count(error_count),
        .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 10)
            send_calm = $urandom_range(40, 10);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic send_item(input logic act, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(act, b);
    endtask

    task automatic send_bytes(input int count, input int tick_max);
        for (int i = 0; i < count; i++)
        begin
            if (tick_max > 0 && $urandom_range(5, 0) == 0)
            begin
                repeat ($urandom_range(tick_max, 1))
                begin
                    send_item(ACT_TICK, 8'($urandom_range(255, 0)));
                    frame_items++;
                end
            end
            send_item(ACT_BYTE, frame_bytes[i]);
            frame_items++;
        end
    endtask

    function automatic void fill_words(input int n);
        int r;
        frame_words = {};
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 15)
                frame_words.push_back(16'h0000);
            else if (r < 30)
                frame_words.push_back(16'hFFFF);
            else
                frame_words.push_back(16'($urandom_range(16'hFFFF, 0)));
        end
    endfunction

    function automatic void build_frame(input logic [7:0] status);
        logic [15:0] c;
        frame_bytes = {};
        frame_bytes.push_back(SFR_VENDOR_BYTE);
        frame_bytes.push_back(status);
        frame_bytes.push_back(8'(frame_words.size()));
        foreach (frame_words[i])
        begin
            frame_bytes.push_back(frame_words[i][15:8]);
            frame_bytes.push_back(frame_words[i][7:0]);
        end
        c = 16'h0000;
        foreach (frame_bytes[i])
            c = sb.crc_step(c, frame_bytes[i]);
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
    endfunction

    function automatic logic [7:0] pick_status();
        return $urandom_range(1, 0) ? SFR_STATUS_FS : SFR_STATUS_OK;
    endfunction

    function automatic int pick_channels();
        int r;
        r = $urandom_range(99, 0);
        if (r < 20)
            return SFR_MIN_CHANNELS;
        if (r < 40)
            return SFR_MAX_CHANNELS;
        return $urandom_range(SFR_MAX_CHANNELS, SFR_MIN_CHANNELS);
    endfunction

    // A frame in progress is ended either by an idle gap or by filler bytes.
    task automatic resync();
        if (sb.position == 0)
            return;
        if (sb.gap_limit <= 8 && $urandom_range(1, 0))
        begin
            repeat (sb.gap_limit)
                send_item(ACT_TICK, 8'($urandom_range(255, 0)));
        end
        else
        begin
            while (sb.position != 0)
                send_item(ACT_BYTE, 8'h00);
        end
    endtask

    task automatic random_phase(input int goal);
        int start;
        int pick;
        int tick_max;
        logic [7:0] b;
        start = frame_items;
        tick_max = (sb.gap_limit > 6) ? 5 : sb.gap_limit - 1;
        while (frame_items - start < goal)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 88)
                resync();
            if (pick < 60)
            begin
                fill_words(pick_channels());
                build_frame(pick_status());
                send_bytes(frame_bytes.size(), tick_max);
            end
            else if (pick < 68)
            begin
                fill_words(pick_channels());
                build_frame(pick_status());
                b = 8'($urandom_range(frame_bytes.size() - 1, SFR_HEAD_LEN));
                frame_bytes[b] = frame_bytes[b] ^ (8'h01 << $urandom_range(7, 0));
                send_bytes(frame_bytes.size(), tick_max);
            end
            else if (pick < 74)
            begin
                b = 8'($urandom_range(255, 0));
                if (b == SFR_STATUS_OK || b == SFR_STATUS_FS)
                    b = b ^ 8'h02;
                frame_bytes = {SFR_VENDOR_BYTE, b};
                send_bytes(2, 0);
            end
            else if (pick < 80)
            begin
                case ($urandom_range(3, 0))
                    0: b = 8'd0;
                    1: b = 8'd1;
                    2: b = 8'(SFR_MAX_CHANNELS + 1);
                    default: b = 8'($urandom_range(255, SFR_MAX_CHANNELS + 1));
                endcase
                frame_bytes = {SFR_VENDOR_BYTE, pick_status(), b};
                send_bytes(3, 0);
            end
            else if (pick < 88)
            begin
                fill_words(pick_channels());
                build_frame(pick_status());
                send_bytes($urandom_range(frame_bytes.size() - 1, 1), tick_max);
                if (sb.gap_limit <= 8)
                    repeat (sb.gap_limit + $urandom_range(2, 0))
                        send_item(ACT_TICK, 8'($urandom_range(255, 0)));
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                    send_item(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.gap_limit = value;
    endtask

    initial
    begin
        int calm;
        int stall_len;
        int r;
        calm = 0;
        stall_len = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (calm > 0)
            begin
                calm--;
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(99, 0);
                if (r < 15)
                    calm = $urandom_range(40, 10);
                else if (r < 40)
                    stall_len = $urandom_range(3, 1);
                else if (r < 43)
                    stall_len = $urandom_range(50, 10);
                out_stall <= (stall_len > 0);
                if (stall_len > 0)
                    stall_len--;
                if (stall_len > 0)
                    calm = 0;
            end
        end
    end

    always @(posedge clk)
    begin
        channel_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind, channel_index, channel_value, channel_total, failsafe,
                   good_count, error_count, last};
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", idle_cycles);
            $display("sumd_frame_receiver_unit_test: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACT_BYTE;
        rx_byte <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_data <= SFR_GAP_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset timeout of four milliseconds.
        frame_words = {16'h0000, 16'hFFFF};
        build_frame(SFR_STATUS_OK);
        send_bytes(frame_bytes.size(), 0);
        send_item(ACT_BYTE, 8'h57);
        frame_bytes = {SFR_VENDOR_BYTE, 8'h00};
        send_bytes(2, 0);
        frame_bytes = {SFR_VENDOR_BYTE, SFR_STATUS_FS, 8'd1};
        send_bytes(3, 0);
        frame_bytes = {SFR_VENDOR_BYTE, SFR_STATUS_OK, 8'd17};
        send_bytes(3, 0);
        frame_bytes = {SFR_VENDOR_BYTE, SFR_STATUS_OK, 8'd2};
        send_bytes(3, 0);
        repeat (3) send_item(ACT_TICK, 8'hFF);
        send_item(ACT_BYTE, 8'h12);
        repeat (4) send_item(ACT_TICK, 8'h00);
        fill_words(2);
        build_frame(SFR_STATUS_FS);
        send_bytes(frame_bytes.size(), 0);
        wait_drained();

        write_gap(8'd1);
        random_phase(PHASE_ITEMS);
        wait_drained();

        write_gap(8'd255);
        fill_words(SFR_MAX_CHANNELS);
        build_frame(SFR_STATUS_OK);
        send_bytes(frame_bytes.size(), 0);
        random_phase(PHASE_ITEMS - 20);
        wait_drained();

        write_gap(8'($urandom_range(12, 3)));
        hold_off_req = 1'b1;
        random_phase(PHASE_ITEMS);
        wait_drained();

        write_gap(8'($urandom_range(254, 13)));
        random_phase(PHASE_ITEMS);
        wait_drained();

        write_gap(SFR_GAP_RESET);
        random_phase(PHASE_ITEMS);
        wait_drained();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        $display("Sent %0d frame requests over gap timeouts 4, 1, 255 and two random values.",
                 frame_items);
        $display("Checked %0d results: %0d good frames, %0d rejected frames.",
                 sb.results_seen, sb.good_frames, sb.bad_frames);
        if (sb.errors == 0)
            $display("sumd_frame_receiver_unit_test: clean");
        else
            $display("sumd_frame_receiver_unit_test: errors");
        $finish;
    end

endmodule
